>>> src/iprx_pkg.sv
// Shared types and constants for the IPv4 receive header filter.
package iprx_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int MIN_HEADER  = 20;

	typedef logic [LENGTH_BITS-1:0] len_t;

	localparam len_t COUNT_MAX = '1;

	localparam logic [7:0]  IHL_MASK    = 8'h0F;
	localparam logic [7:0]  MCAST_MASK  = 8'hF0;
	localparam logic [7:0]  MCAST_TAG   = 8'hE0;
	localparam logic [15:0] CSUM_GOOD   = 16'hFFFF;
	localparam logic [31:0] BCAST_ADDR  = {8'd255, 8'd255, 8'd255, 8'd255};
	localparam logic [3:0]  IP_VERSION4 = 4'd4;

	typedef enum logic [2:0] {
		V_ACCEPT    = 3'd0,
		V_DISABLED  = 3'd1,
		V_SHORT     = 3'd2,
		V_BAD_VER   = 3'd3,
		V_BAD_HLEN  = 3'd4,
		V_BAD_CSUM  = 3'd5,
		V_NOT_OURS  = 3'd6
	} verdict_t;

	typedef enum logic [0:0] {
		CFG_ENABLE   = 1'b0,
		CFG_OUR_ADDR = 1'b1
	} cfg_reg_t;

	// packet state as it stands once the current beat is applied
	typedef struct packed {
		len_t        len;
		logic [15:0] csum;
		logic [7:0]  vl_byte;
		logic [7:0]  protocol;
		logic [31:0] src;
		logic [31:0] dst;
	} pkt_view_t;

endpackage

>>> src/iprx_byte_if.sv
// Byte stream channel: one packet byte per beat with a last-byte mark.
interface iprx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

>>> src/iprx_result_if.sv
// Verdict channel: one beat per packet.
interface iprx_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  protocol;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [5:0]  header_bytes;
	logic [15:0] payload_bytes;
	logic        is_multicast;

	modport source (output valid, verdict, protocol, source_address, dest_address,
		header_bytes, payload_bytes, is_multicast, input ready);
	modport sink   (input valid, verdict, protocol, source_address, dest_address,
		header_bytes, payload_bytes, is_multicast, output ready);
endinterface

>>> src/iprx_cfg_if.sv
// Register write channel.
interface iprx_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ipv4_rx_header_filter.sv
// IPv4 receive header filter: byte-wise header check with one verdict per packet.
//
//  channel | dir | beat
//  pkt     | in  | one packet byte, last_byte on the final one
//  res     | out | verdict with captured header fields, one per packet
//  cfg     | in  | register write (index 0 enable, index 1 our_address)
//
// One byte per cycle sustained while the result is not stalled. A byte is held in
// the input register, then updates the packet state; on the last byte the verdict
// is loaded into the result register at that same edge. Reset clears the valid flags,
// the configuration and all packet state. A stalled result holds the whole pipeline;
// the input register still takes a beat while it is empty.
module ipv4_rx_header_filter (
	input  logic      clk,
	input  logic      arst_n,
	iprx_byte_if.sink   pkt,
	iprx_result_if.source res,
	iprx_cfg_if.sink    cfg
);
	import iprx_pkg::*;

	logic        enable_q;
	logic [31:0] our_addr_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	logic        advance;
	logic        apply;
	pkt_view_t   view;

	logic [5:0]  ihl;
	len_t        ihl_w;
	logic        mcast;
	verdict_t    verdict;
	logic [15:0] payload;

	logic        res_valid_q;
	verdict_t    verdict_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [5:0]  hdr_q;
	logic [15:0] payload_q;
	logic        mcast_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			our_addr_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_ENABLE:   enable_q   <= cfg.data[0];
				CFG_OUR_ADDR: our_addr_q <= cfg.data;
				default:      ;
			endcase
		end
	end

	// input register
	assign advance   = !res_valid_q || res.ready;
	assign pkt.ready = !valid_s1 || advance;
	assign apply     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	iprx_hdr_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.apply  (apply),
		.data   (data_s1),
		.last   (last_s1),
		.view   (view)
	);

	// verdict, checks in priority order
	always_comb begin
		ihl     = {view.vl_byte[3:0] & IHL_MASK[3:0], 2'b00};
		ihl_w   = {{(LENGTH_BITS-6){1'b0}}, ihl};
		mcast   = (view.dst[31:24] & MCAST_MASK) == MCAST_TAG;
		payload = '0;
		if (!enable_q) begin
			verdict = V_DISABLED;
		end else if (view.len < len_t'(MIN_HEADER)) begin
			verdict = V_SHORT;
		end else if (view.vl_byte[7:4] != IP_VERSION4) begin
			verdict = V_BAD_VER;
		end else if (ihl < 6'(MIN_HEADER) || ihl_w > view.len) begin
			verdict = V_BAD_HLEN;
		end else if (view.csum != CSUM_GOOD) begin
			verdict = V_BAD_CSUM;
		end else if (!mcast && view.dst != our_addr_q && view.dst != BCAST_ADDR) begin
			verdict = V_NOT_OURS;
		end else begin
			verdict = V_ACCEPT;
			payload = 16'(view.len - ihl_w);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= apply && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (apply && last_s1) begin
			verdict_q <= verdict;
			proto_q   <= view.protocol;
			src_q     <= view.src;
			dst_q     <= view.dst;
			hdr_q     <= ihl;
			payload_q <= payload;
			mcast_q   <= mcast;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.verdict        = verdict_q;
	assign res.protocol       = proto_q;
	assign res.source_address = src_q;
	assign res.dest_address   = dst_q;
	assign res.header_bytes   = hdr_q;
	assign res.payload_bytes  = payload_q;
	assign res.is_multicast   = mcast_q;

	// a verdict only follows a last byte
	a_res_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(apply && last_s1))
		else $error("result without a last byte");

	a_payload_only_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && verdict_q != V_ACCEPT |-> payload_q == '0)
		else $error("payload length on a dropped packet");

	a_accept_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && verdict_q == V_ACCEPT |-> hdr_q >= 6'(MIN_HEADER))
		else $error("accepted packet with short header");

	a_mcast_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> mcast_q == ((dst_q[31:24] & MCAST_MASK) == MCAST_TAG))
		else $error("multicast flag disagrees with destination");

endmodule

>>> src/iprx_hdr_acc.sv
// Per-packet byte counter, header checksum accumulator and field capture.
module iprx_hdr_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               apply,
	input  logic [7:0]         data,
	input  logic               last,
	output iprx_pkg::pkt_view_t view
);
	import iprx_pkg::*;

	len_t        cnt_q;
	logic [15:0] csum_q;
	logic [7:0]  hi_q;
	logic [7:0]  vl_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;

	logic [7:0]  vl;
	logic [5:0]  ihl;
	len_t        ihl_w;
	logic        in_hdr;
	logic [16:0] sum17;
	logic [15:0] csum_nxt;
	logic [7:0]  hi_nxt;
	logic [7:0]  proto_nxt;
	logic [31:0] src_nxt;
	logic [31:0] dst_nxt;
	len_t        cnt_nxt;

	always_comb begin
		vl     = (cnt_q == '0) ? data : vl_q;
		ihl    = {vl[3:0] & IHL_MASK[3:0], 2'b00};
		ihl_w  = {{(LENGTH_BITS-6){1'b0}}, ihl};
		in_hdr = cnt_q < ihl_w;

		// end-around carry: a single fold is enough for two 16-bit operands
		sum17    = {1'b0, csum_q} + {1'b0, hi_q, data};
		csum_nxt = csum_q;
		hi_nxt   = hi_q;
		if (in_hdr) begin
			if (!cnt_q[0]) begin
				hi_nxt = data;
			end else begin
				csum_nxt = sum17[15:0] + {15'd0, sum17[16]};
			end
		end

		proto_nxt = proto_q;
		src_nxt   = src_q;
		dst_nxt   = dst_q;
		if (cnt_q == len_t'(9)) begin
			proto_nxt = data;
		end else if (cnt_q >= len_t'(12) && cnt_q <= len_t'(15)) begin
			src_nxt = {src_q[23:0], data};
		end else if (cnt_q >= len_t'(16) && cnt_q <= len_t'(19)) begin
			dst_nxt = {dst_q[23:0], data};
		end

		cnt_nxt = (cnt_q != COUNT_MAX) ? cnt_q + len_t'(1) : cnt_q;

		view.len      = cnt_nxt;
		view.csum     = csum_nxt;
		view.vl_byte  = vl;
		view.protocol = proto_nxt;
		view.src      = src_nxt;
		view.dst      = dst_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			csum_q  <= '0;
			hi_q    <= '0;
			vl_q    <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else if (apply) begin
			if (last) begin
				cnt_q   <= '0;
				csum_q  <= '0;
				hi_q    <= '0;
				vl_q    <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
			end else begin
				cnt_q   <= cnt_nxt;
				csum_q  <= csum_nxt;
				hi_q    <= hi_nxt;
				vl_q    <= vl;
				proto_q <= proto_nxt;
				src_q   <= src_nxt;
				dst_q   <= dst_nxt;
			end
		end
	end

endmodule

>>> tb/tb_ipv4_rx_header_filter.sv
// Self-checking testbench for the IPv4 receive header filter.
`timescale 1ns / 1ps

module tb_ipv4_rx_header_filter;
	import iprx_pkg::*;

	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_byte_t;

	typedef struct {
		verdict_t    verdict;
		logic [7:0]  protocol;
		logic [31:0] src;
		logic [31:0] dst;
		logic [5:0]  hdr_bytes;
		logic [15:0] payload;
		logic        mcast;
	} ip_verdict_t;

	logic clk;
	logic arst_n;

	iprx_byte_if   pkt_ch ();
	iprx_result_if res_ch ();
	iprx_cfg_if    cfg_ch ();

	ipv4_rx_header_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// filter state as the block should hold it
	logic        cfg_enable   = 1'b0;
	logic [31:0] cfg_our_addr = '0;
	len_t        rx_count     = '0;
	logic [15:0] rx_sum       = '0;
	logic [7:0]  rx_hi        = '0;
	logic [7:0]  rx_vl        = '0;
	logic [7:0]  rx_proto     = '0;
	logic [31:0] rx_src       = '0;
	logic [31:0] rx_dst       = '0;

	rx_byte_t    tx_bytes[$];
	ip_verdict_t pending_verdicts[$];
	logic [7:0]  pkt_buf[$];

	bit          hold_send = 1'b0;
	bit          no_idle   = 1'b0;
	int unsigned send_gap;
	int unsigned take_wait;
	int unsigned stuck_cycles;
	int          bad_count     = 0;
	int          bytes_queued  = 0;
	int          pkts_queued   = 0;
	int          reg_writes    = 0;
	int          checked_count = 0;
	int          verdict_hits[8];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// apply one accepted beat; on the last byte work out the verdict
	task automatic track_byte(input logic [7:0] b, input logic is_last);
		len_t        idx;
		logic [5:0]  hlen;
		logic [16:0] s;
		ip_verdict_t want;
		idx = rx_count;
		if (idx == 0)
			rx_vl = b;
		hlen = {rx_vl[3:0], 2'b00};
		if (idx < hlen) begin
			if (!idx[0]) begin
				rx_hi = b;
			end else begin
				s = {1'b0, rx_sum} + {1'b0, rx_hi, b};
				s = s[15:0] + s[16];
				rx_sum = s[15:0];
			end
		end
		if (idx == 9)
			rx_proto = b;
		else if (idx >= 12 && idx <= 15)
			rx_src = {rx_src[23:0], b};
		else if (idx >= 16 && idx <= 19)
			rx_dst = {rx_dst[23:0], b};
		if (rx_count != COUNT_MAX)
			rx_count++;
		if (is_last) begin
			want.protocol  = rx_proto;
			want.src       = rx_src;
			want.dst       = rx_dst;
			want.hdr_bytes = hlen;
			want.payload   = '0;
			want.mcast     = (rx_dst[31:24] & MCAST_MASK) == MCAST_TAG;
			if (!cfg_enable)
				want.verdict = V_DISABLED;
			else if (rx_count < MIN_HEADER)
				want.verdict = V_SHORT;
			else if (rx_vl[7:4] != IP_VERSION4)
				want.verdict = V_BAD_VER;
			else if (hlen < MIN_HEADER || hlen > rx_count)
				want.verdict = V_BAD_HLEN;
			else if (rx_sum != CSUM_GOOD)
				want.verdict = V_BAD_CSUM;
			else if (!want.mcast && rx_dst != cfg_our_addr && rx_dst != BCAST_ADDR)
				want.verdict = V_NOT_OURS;
			else begin
				want.verdict = V_ACCEPT;
				want.payload = rx_count - hlen;
			end
			pending_verdicts.push_back(want);
			rx_count = '0;
			rx_sum   = '0;
			rx_hi    = '0;
			rx_vl    = '0;
			rx_proto = '0;
			rx_src   = '0;
			rx_dst   = '0;
		end
	endtask

	always @(posedge clk) begin : drive_bytes
		rx_byte_t nxt;
		if (!arst_n) begin
			pkt_ch.valid     <= 1'b0;
			pkt_ch.data_byte <= '0;
			pkt_ch.last_byte <= 1'b0;
			send_gap = 0;
		end else begin
			if (pkt_ch.valid && pkt_ch.ready)
				track_byte(pkt_ch.data_byte, pkt_ch.last_byte);
			if (!pkt_ch.valid || pkt_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					pkt_ch.valid <= 1'b0;
				end else if (hold_send || tx_bytes.size() == 0) begin
					pkt_ch.valid <= 1'b0;
				end else begin
					nxt = tx_bytes.pop_front();
					pkt_ch.valid     <= 1'b1;
					pkt_ch.data_byte <= nxt.data;
					pkt_ch.last_byte <= nxt.last;
					send_gap = no_idle ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	always @(posedge clk) begin : check_verdicts
		ip_verdict_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			take_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("[%0t] unexpected verdict beat: v=%0d dst=%h", $time,
							res_ch.verdict, res_ch.dest_address);
				end else begin
					want = pending_verdicts.pop_front();
					checked_count++;
					verdict_hits[want.verdict]++;
					if (res_ch.verdict !== want.verdict || res_ch.protocol !== want.protocol
						|| res_ch.source_address !== want.src
						|| res_ch.dest_address !== want.dst
						|| res_ch.header_bytes !== want.hdr_bytes
						|| res_ch.payload_bytes !== want.payload
						|| res_ch.is_multicast !== want.mcast) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("[%0t] mismatch exp: v=%0d pr=%h src=%h dst=%h hb=%0d pl=%0d mc=%b",
								$time, want.verdict, want.protocol, want.src, want.dst,
								want.hdr_bytes, want.payload, want.mcast);
							$display("            got: v=%0d pr=%h src=%h dst=%h hb=%0d pl=%0d mc=%b",
								res_ch.verdict, res_ch.protocol, res_ch.source_address,
								res_ch.dest_address, res_ch.header_bytes,
								res_ch.payload_bytes, res_ch.is_multicast);
						end
					end
				end
				take_wait = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (take_wait != 0) begin
				take_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// no beat on any channel for too long means the block has hung
	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles = 0;
		end else if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d verdicts outstanding",
					STALL_LIMIT, pending_verdicts.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_ENABLE)
			cfg_enable = val[0];
		else
			cfg_our_addr = val;
		reg_writes++;
	endtask

	// header with given fields, random filler, truncated to total bytes
	task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl_n,
		input int total, input logic [7:0] proto, input logic [31:0] src,
		input logic [31:0] dst, input bit good_csum);
		int          hdr;
		int          k;
		logic [16:0] s;
		hdr = (ihl_n * 4 < 20) ? 20 : ihl_n * 4;
		pkt_buf = {};
		for (k = 0; k < ((hdr > total) ? hdr : total); k++)
			pkt_buf.push_back(8'($urandom_range(0, 255)));
		pkt_buf[0]  = {ver, ihl_n};
		pkt_buf[2]  = total[15:8];
		pkt_buf[3]  = total[7:0];
		pkt_buf[9]  = proto;
		pkt_buf[10] = '0;
		pkt_buf[11] = '0;
		for (k = 0; k < 4; k++) begin
			pkt_buf[12 + k] = src[31 - 8 * k -: 8];
			pkt_buf[16 + k] = dst[31 - 8 * k -: 8];
		end
		if (good_csum) begin
			s = '0;
			for (k = 0; k < ihl_n * 4; k += 2) begin
				s = {1'b0, s[15:0]} + {1'b0, pkt_buf[k], pkt_buf[k + 1]};
				s = s[15:0] + s[16];
			end
			{pkt_buf[10], pkt_buf[11]} = ~s[15:0];
		end else begin
			pkt_buf[11] = 8'($urandom_range(0, 255));
		end
		while (pkt_buf.size() > total)
			void'(pkt_buf.pop_back());
	endtask

	task automatic send_packet();
		int k;
		@(negedge clk);
		for (k = 0; k < pkt_buf.size(); k++)
			tx_bytes.push_back('{data: pkt_buf[k], last: (k == pkt_buf.size() - 1)});
		bytes_queued += pkt_buf.size();
		pkts_queued++;
	endtask

	task automatic queue_random_packet();
		int          kind;
		int          total;
		int          k;
		logic [3:0]  ver;
		logic [3:0]  ihl_n;
		logic [31:0] dst;
		bit          good;
		kind  = $urandom_range(0, 99);
		ver   = IP_VERSION4;
		ihl_n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		total = ihl_n * 4 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
			: $urandom_range(0, 16));
		good  = 1'b1;
		case ($urandom_range(0, 3))
			0: dst = cfg_our_addr;
			1: dst = BCAST_ADDR;
			2: dst = {4'hE, 28'($urandom)};
			default: dst = $urandom;
		endcase
		if (kind >= 70 && kind < 76) begin
			ver = 4'($urandom_range(0, 15));
		end else if (kind >= 76 && kind < 82) begin
			ihl_n = 4'($urandom_range(0, 4));
		end else if (kind >= 82 && kind < 86) begin
			// header claims more than the packet holds
			ihl_n = 4'($urandom_range(6, 15));
			total = $urandom_range(20, ihl_n * 4 - 1);
		end else if (kind >= 86 && kind < 91) begin
			good = 1'b0;
		end else if (kind >= 91 && kind < 95) begin
			total = $urandom_range(1, 19);
		end
		if (kind >= 95) begin
			pkt_buf = {};
			for (k = 0; k < $urandom_range(1, 40); k++)
				pkt_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			build_packet(ver, ihl_n, total, 8'($urandom_range(0, 255)), $urandom, dst, good);
		end
		send_packet();
	endtask

	// wait for every beat to go in and every verdict to come back
	task automatic drain();
		do @(negedge clk);
		while (tx_bytes.size() != 0 || pkt_ch.valid || pending_verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin : stimulus
		int          phase;
		int          k;
		int          start_bytes;
		logic [31:0] addr;
		arst_n           = 1'b0;
		pkt_ch.valid     = 1'b0;
		pkt_ch.data_byte = '0;
		pkt_ch.last_byte = 1'b0;
		res_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_ENABLE;
		cfg_ch.data      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// still disabled out of reset
		build_packet(IP_VERSION4, 5, 28, 8'h11, 32'h0A000001, BCAST_ADDR, 1'b1);
		send_packet();
		drain();
		write_reg(CFG_OUR_ADDR, 32'hC0A80105);
		write_reg(CFG_ENABLE, 32'd1);

		pkt_buf = {8'hFF};
		send_packet();
		build_packet(IP_VERSION4, 5, 19, 8'h06, 32'h01020304, cfg_our_addr, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 5, 20, 8'h00, 32'h0, cfg_our_addr, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 15, 64, 8'hFF, 32'hFFFFFFFF, BCAST_ADDR, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 5, 30, 8'h11, $urandom, 32'hE0000001, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 6, 40, 8'h11, $urandom, 32'hEFFFFFFF, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 5, 30, 8'h11, $urandom, 32'hF0000001, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 5, 30, 8'h06, $urandom, 32'h0A0A0A0A, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 5, 30, 8'h06, $urandom, cfg_our_addr, 1'b0);
		send_packet();
		build_packet(4'd6, 5, 40, 8'h06, $urandom, cfg_our_addr, 1'b1);
		send_packet();
		build_packet(4'd0, 0, 20, 8'h00, 32'h0, 32'h0, 1'b1);
		send_packet();
		pkt_buf = {};
		for (k = 0; k < 24; k++)
			pkt_buf.push_back(8'hFF);
		send_packet();
		build_packet(IP_VERSION4, 0, 40, 8'h01, $urandom, cfg_our_addr, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 4, 40, 8'h01, $urandom, cfg_our_addr, 1'b1);
		send_packet();
		build_packet(IP_VERSION4, 15, 40, 8'h01, $urandom, cfg_our_addr, 1'b1);
		send_packet();
		drain();

		// sender holds off until the block has nothing left in flight
		for (k = 0; k < 2; k++)
			queue_random_packet();
		while (pending_verdicts.size() == 0)
			@(negedge clk);
		hold_send = 1'b1;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		hold_send = 1'b0;
		drain();

		for (phase = 0; phase < 8; phase++) begin
			no_idle = (phase % 3 == 2);
			case (phase)
				1: addr = '0;
				2: addr = '1;
				default: addr = $urandom;
			endcase
			write_reg(CFG_OUR_ADDR, addr);
			write_reg(CFG_ENABLE, (phase == 5) ? 32'd0 : 32'd1);
			start_bytes = bytes_queued;
			while (bytes_queued - start_bytes < 16)
				queue_random_packet();
			drain();
		end

		repeat (10) @(negedge clk);
		bad_count += pending_verdicts.size();
		$display("Sent %0d bytes in %0d packets over %0d register writes; %0d verdicts checked.",
			bytes_queued, pkts_queued, reg_writes, checked_count);
		$display("Verdict mix accept/off/short/ver/hlen/csum/dest: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
			verdict_hits[V_ACCEPT], verdict_hits[V_DISABLED], verdict_hits[V_SHORT],
			verdict_hits[V_BAD_VER], verdict_hits[V_BAD_HLEN], verdict_hits[V_BAD_CSUM],
			verdict_hits[V_NOT_OURS]);
		if (bad_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
